FILE: design/ground_plane_pose_integrator_defines.svh
// Assertion macros for the ground-plane pose integrator.
`ifndef GROUND_PLANE_POSE_INTEGRATOR_DEFINES_SVH
`define GROUND_PLANE_POSE_INTEGRATOR_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication under the asynchronous reset.
`define GPPI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// Next-cycle implication under the asynchronous reset.
`define GPPI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`else

`define GPPI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define GPPI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: design/gppi_pkg.sv
// Types and constants shared by the ground-plane pose integrator.
`timescale 1ns / 1ps
package gppi_pkg;

	localparam int ENT_W      = 20;
	localparam int ROW_W      = 3 * ENT_W;
	localparam int POS_W      = 32;
	localparam int OPB_W      = POS_W + 1;
	localparam int PROD_W     = ENT_W + OPB_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int NORM_SHIFT = 10;
	localparam int SQ_W       = 2 * ENT_W;
	localparam int ROOT_W     = 30;
	localparam int X_W        = 2 * ROOT_W;
	localparam int QUO_W      = ENT_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int STEP_W     = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ROW_W;

	localparam logic signed [ENT_W-1:0] ENT_MAX = 20'sh7FFFF;
	localparam logic signed [ENT_W-1:0] ENT_MIN = 20'sh80000;
	localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFFFFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;

	localparam logic [1:0] OP_NEXT_SPACE  = 2'd0;
	localparam logic [1:0] OP_LOAD_GROUND = 2'd1;
	localparam logic [1:0] OP_LOAD_SPACE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POS_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Z    = 3'd5;

	typedef logic [2:0][2:0][ENT_W-1:0] mat_t;
	typedef logic [2:0][POS_W-1:0] vec_t;
	typedef logic [2:0][OPB_W-1:0] opv_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_SQRT,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_END,
		ST_ALIGN,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		PS_REL_ROT,
		PS_REL_POS,
		PS_GND_ROT,
		PS_GND_POS,
		PS_LOAD_ROT,
		PS_LOAD_POS,
		PS_NORM_SQ,
		PS_OUT_ROT,
		PS_OUT_POS
	} pass_t;

	typedef struct packed {
		logic [1:0]              operation;
		logic [ROW_W-1:0]        rot_row0;
		logic [ROW_W-1:0]        rot_row1;
		logic [ROW_W-1:0]        rot_row2;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} pose_t;

	typedef struct packed {
		logic [ROW_W-1:0]        out_rot_row0;
		logic [ROW_W-1:0]        out_rot_row1;
		logic [ROW_W-1:0]        out_rot_row2;
		logic signed [POS_W-1:0] out_pos_x;
		logic signed [POS_W-1:0] out_pos_y;
		logic signed [POS_W-1:0] out_pos_z;
		logic                    degenerate;
	} result_t;

endpackage

FILE: design/ground_plane_pose_integrator.sv
// Top level of the ground-plane pose integrator: sequencer and shared arithmetic datapath.
`timescale 1ns / 1ps
`include "ground_plane_pose_integrator_defines.svh"

// The block keeps the last space pose and a ground-plane pose. A pose request
// with operation 0 forms the motion relative to the stored space pose, applies
// it to the ground pose, drops the height, removes roll and pitch by
// renormalizing the forward axis in the ground plane, and stores the new space
// pose. Operation 1 loads the ground pose from a world pose, operation 2 loads
// the space pose, and every request returns exactly one result: the ground
// pose mapped into world by the configuration registers. All arithmetic runs
// through one 20 x 33 bit multiply-accumulate unit, one element of a product at
// a time, followed by a bit-serial square root and a bit-serial divider that
// runs once for each of the two axis entries; a degenerate forward axis skips
// the root and the divider. The block takes one request at a time and holds
// pose_stall high until the result sits in the output register; it takes the
// next request while that result still waits for the consumer.
module ground_plane_pose_integrator #(
	parameter int ROT_FRAC_BITS = 18
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pose_valid,
	output logic                              pose_stall,
	input  gppi_pkg::pose_t                   pose,
	output logic                              result_valid,
	input  logic                              result_stall,
	output gppi_pkg::result_t                 result,
	input  logic                              cfg_write,
	input  logic [gppi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gppi_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gppi_pkg::*;

	// Fixed-point constants that follow the rotation scaling.
	localparam logic signed [ENT_W-1:0] ENT_ONE = (ROT_FRAC_BITS >= ENT_W - 1) ?
		ENT_MAX : ENT_W'(64'd1 << ROT_FRAC_BITS);
	localparam mat_t ID_MAT = {ENT_ONE, ENT_W'(0), ENT_W'(0),
		ENT_W'(0), ENT_ONE, ENT_W'(0),
		ENT_W'(0), ENT_W'(0), ENT_ONE};
	localparam logic [ROW_W-1:0] W_ROW0_RST = ROW_W'(128'd1 << (2 * ENT_W + ROT_FRAC_BITS));
	localparam logic [ROW_W-1:0] W_ROW1_RST = ROW_W'(128'd1 << (ENT_W + ROT_FRAC_BITS));
	localparam logic [ROW_W-1:0] W_ROW2_RST = ROW_W'(128'd1 << ROT_FRAC_BITS);
	localparam int SUM_W = ((ACC_W > POS_W + ROT_FRAC_BITS) ? ACC_W : POS_W + ROT_FRAC_BITS) + 2;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'd1 << (ROT_FRAC_BITS - 1));
	localparam logic signed [SUM_W-1:0] S_ENT_MAX = SUM_W'(ENT_MAX);
	localparam logic signed [SUM_W-1:0] S_ENT_MIN = SUM_W'(ENT_MIN);
	localparam logic signed [SUM_W-1:0] S_POS_MAX = SUM_W'(POS_MAX);
	localparam logic signed [SUM_W-1:0] S_POS_MIN = SUM_W'(POS_MIN);
	localparam int NUM_W = ENT_W + ROT_FRAC_BITS + NORM_SHIFT + 1;
	localparam int CMP_W = (NUM_W > ROOT_W + QUO_W) ? NUM_W : ROOT_W + QUO_W;

	// Control state.
	state_t state_q, state_d;
	pass_t  pass_q, pass_d;
	logic [2:0] cyc_q;
	logic [1:0] ii_q, jj_q;
	logic [STEP_W-1:0] step_q;
	logic dsel_q;
	logic result_valid_q;

	// Configuration registers (world from ground).
	logic [2:0][ROW_W-1:0] wrow_q;
	vec_t wpos_q;

	// Pose state and scratch.
	pose_t pin_q;
	logic [1:0] op_q;
	mat_t gr_q, sr_q, ta_q, tb_q;
	vec_t gt_q, st_q, trel_q, tt_q;
	logic deg_q;

	// Shared multiply-accumulate unit.
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;

	// Root and divider registers.
	logic [X_W-1:0]    sq_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic              dsat_q, dneg_q;
	logic signed [ENT_W-1:0] ua_q, uc_q;

	result_t result_q;

	// Decoded operands.
	mat_t wmat, pmat, a_mat, b_mat;
	vec_t ppos;
	opv_t b_vec;
	logic a_tr, b_is_mat, pass_vec, pass_last;
	logic signed [POS_W-1:0] addend;
	logic [1:0] kidx;
	logic signed [ENT_W-1:0] a_op;
	logic signed [OPB_W-1:0] b_op;
	logic signed [SUM_W-1:0] fsum, rnd;
	logic signed [ENT_W-1:0] ent_sat;
	logic signed [POS_W-1:0] pos_sat;
	logic accept, elem_end;

	// Divider set-up and square-root / divider steps.
	logic signed [ENT_W-1:0] dv;
	logic [ENT_W-1:0]  dmag;
	logic [NUM_W-1:0]  num;
	logic [REM_W-1:0]  sq_rem, sq_trial;
	logic [ROOT_W:0]   dv_rem;
	logic signed [ENT_W-1:0] unit;

	// Ground rotation rebuilt from the unit forward axis.
	mat_t align_mat;

	// First column of the output rotation, used by the checks below.
	logic out_col0_zero;

	assign accept       = pose_valid && (state_q == ST_IDLE);
	assign pose_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign kidx         = (cyc_q < 3'd3) ? cyc_q[1:0] : 2'd0;
	assign elem_end     = (state_q == ST_MAC) && (cyc_q == 3'd4);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				wmat[i][j] = wrow_q[i][(2 - j) * ENT_W +: ENT_W];
			end
		end
		for (int j = 0; j < 3; j++) begin
			pmat[0][j] = pin_q.rot_row0[(2 - j) * ENT_W +: ENT_W];
			pmat[1][j] = pin_q.rot_row1[(2 - j) * ENT_W +: ENT_W];
			pmat[2][j] = pin_q.rot_row2[(2 - j) * ENT_W +: ENT_W];
		end
		ppos[0] = pin_q.pos_x;
		ppos[1] = pin_q.pos_y;
		ppos[2] = pin_q.pos_z;
	end

	// Next state and next pass.
	always_comb begin
		state_d = state_q;
		pass_d  = pass_q;
		case (state_q)
			ST_IDLE: begin
				if (pose_valid) begin
					state_d = ST_MAC;
					case (pose.operation)
						OP_NEXT_SPACE:  pass_d = PS_REL_ROT;
						OP_LOAD_GROUND: pass_d = PS_LOAD_ROT;
						default:        pass_d = PS_OUT_ROT;
					endcase
				end
			end
			ST_MAC: begin
				if (elem_end && pass_last) begin
					case (pass_q)
						PS_REL_ROT:  pass_d = PS_REL_POS;
						PS_REL_POS:  pass_d = PS_GND_ROT;
						PS_GND_ROT:  pass_d = PS_GND_POS;
						PS_GND_POS:  pass_d = PS_NORM_SQ;
						PS_LOAD_ROT: pass_d = PS_LOAD_POS;
						PS_LOAD_POS: pass_d = PS_NORM_SQ;
						PS_NORM_SQ:  state_d = (acc_q == '0) ? ST_ALIGN : ST_SQRT;
						PS_OUT_ROT:  pass_d = PS_OUT_POS;
						PS_OUT_POS:  state_d = ST_DONE;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_SQRT: begin
				if (step_q == STEP_W'(ROOT_W - 1)) begin
					state_d = ST_DIV_INIT;
				end
			end
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_W'(QUO_W - 1)) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: state_d = dsel_q ? ST_ALIGN : ST_DIV_INIT;
			ST_ALIGN: begin
				state_d = ST_MAC;
				pass_d  = PS_OUT_ROT;
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Operand routing for the current pass.
	always_comb begin
		a_mat    = wmat;
		a_tr     = 1'b0;
		b_mat    = gr_q;
		b_is_mat = 1'b1;
		b_vec    = '0;
		addend   = '0;
		pass_vec = 1'b0;
		case (pass_q)
			PS_REL_ROT: begin
				a_mat = sr_q;
				a_tr  = 1'b1;
				b_mat = pmat;
			end
			PS_REL_POS: begin
				a_mat    = sr_q;
				a_tr     = 1'b1;
				b_is_mat = 1'b0;
				pass_vec = 1'b1;
				for (int k = 0; k < 3; k++) begin
					b_vec[k] = OPB_W'($signed(ppos[k])) - OPB_W'($signed(st_q[k]));
				end
			end
			PS_GND_ROT: begin
				a_mat = gr_q;
				b_mat = ta_q;
			end
			PS_GND_POS: begin
				a_mat    = gr_q;
				b_is_mat = 1'b0;
				pass_vec = 1'b1;
				addend   = $signed(gt_q[ii_q]);
				for (int k = 0; k < 3; k++) begin
					b_vec[k] = OPB_W'($signed(trel_q[k]));
				end
			end
			PS_LOAD_ROT: begin
				a_tr  = 1'b1;
				b_mat = pmat;
			end
			PS_LOAD_POS: begin
				a_tr     = 1'b1;
				b_is_mat = 1'b0;
				pass_vec = 1'b1;
				for (int k = 0; k < 3; k++) begin
					b_vec[k] = OPB_W'($signed(ppos[k])) - OPB_W'($signed(wpos_q[k]));
				end
			end
			PS_NORM_SQ: begin
				pass_vec = 1'b1;
			end
			PS_OUT_ROT: begin
				b_mat = gr_q;
			end
			PS_OUT_POS: begin
				b_is_mat = 1'b0;
				pass_vec = 1'b1;
				addend   = $signed(wpos_q[ii_q]);
				for (int k = 0; k < 3; k++) begin
					b_vec[k] = OPB_W'($signed(gt_q[k]));
				end
			end
			default: ;
		endcase

		if (pass_q == PS_NORM_SQ) begin
			// Squared length of the forward axis in the ground plane.
			case (kidx)
				2'd0:    a_op = $signed(tb_q[0][0]);
				2'd1:    a_op = $signed(tb_q[2][0]);
				default: a_op = '0;
			endcase
			b_op = OPB_W'(a_op);
		end else begin
			a_op = a_tr ? $signed(a_mat[kidx][ii_q]) : $signed(a_mat[ii_q][kidx]);
			b_op = b_is_mat ? OPB_W'($signed(b_mat[kidx][jj_q])) : $signed(b_vec[kidx]);
		end

		pass_last = (pass_q == PS_NORM_SQ) ||
			((ii_q == 2'd2) && (pass_vec || (jj_q == 2'd2)));

		// Round half up and add the translation in one sum.
		fsum = SUM_W'(acc_q) + (SUM_W'(addend) <<< ROT_FRAC_BITS) + HALF;
		rnd  = fsum >>> ROT_FRAC_BITS;
		if (rnd > S_ENT_MAX) begin
			ent_sat = ENT_MAX;
		end else if (rnd < S_ENT_MIN) begin
			ent_sat = ENT_MIN;
		end else begin
			ent_sat = ENT_W'(rnd);
		end
		if (rnd > S_POS_MAX) begin
			pos_sat = POS_MAX;
		end else if (rnd < S_POS_MIN) begin
			pos_sat = POS_MIN;
		end else begin
			pos_sat = POS_W'(rnd);
		end
	end

	// Root and divider step logic.
	always_comb begin
		dv   = dsel_q ? $signed(tb_q[2][0]) : $signed(tb_q[0][0]);
		dmag = dv[ENT_W-1] ? ENT_W'(-(ENT_W + 1)'(dv)) : ENT_W'(dv);
		num  = (NUM_W'(dmag) << (ROT_FRAC_BITS + NORM_SHIFT)) + NUM_W'(root_q >> 1);

		sq_rem   = {rem_q[REM_W-3:0], sq_q[X_W-1 -: 2]};
		sq_trial = {1'b0, root_q, 2'b01};
		dv_rem   = {rem_q[ROOT_W-1:0], sq_q[X_W-1]};

		if (dsat_q || quo_q[QUO_W-1]) begin
			unit = dneg_q ? ENT_MIN : ENT_MAX;
		end else begin
			unit = dneg_q ? -$signed(quo_q) : $signed(quo_q);
		end
	end

	// The alignment keeps only the forward axis; a zero axis leaves it zero.
	always_comb begin
		align_mat       = '0;
		align_mat[1][1] = ENT_ONE;
		if (!deg_q) begin
			align_mat[0][0] = ua_q;
			align_mat[2][0] = uc_q;
			align_mat[0][2] = (uc_q == ENT_MIN) ? ENT_MAX : -uc_q;
			align_mat[2][2] = ua_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pass_q         <= PS_OUT_ROT;
			cyc_q          <= '0;
			ii_q           <= '0;
			jj_q           <= '0;
			step_q         <= '0;
			dsel_q         <= 1'b0;
			result_valid_q <= 1'b0;
			wrow_q[0]      <= W_ROW0_RST;
			wrow_q[1]      <= W_ROW1_RST;
			wrow_q[2]      <= W_ROW2_RST;
			wpos_q         <= '0;
			gr_q           <= ID_MAT;
			sr_q           <= ID_MAT;
			gt_q  <= '0;
			st_q  <= '0;
			deg_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;

			if (cfg_write) begin
				case (cfg_index)
					REG_ROT_ROW0: wrow_q[0] <= cfg_data;
					REG_ROT_ROW1: wrow_q[1] <= cfg_data;
					REG_ROT_ROW2: wrow_q[2] <= cfg_data;
					REG_POS_X:    wpos_q[0] <= cfg_data[POS_W-1:0];
					REG_POS_Y:    wpos_q[1] <= cfg_data[POS_W-1:0];
					REG_POS_Z:    wpos_q[2] <= cfg_data[POS_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				deg_q <= 1'b0;
			end

			// Element counters of the multiply-accumulate passes.
			if (state_q == ST_MAC) begin
				if (elem_end) begin
					cyc_q <= '0;
					if (pass_last) begin
						ii_q <= '0;
						jj_q <= '0;
					end else if (pass_vec || (jj_q == 2'd2)) begin
						ii_q <= ii_q + 2'd1;
						jj_q <= '0;
					end else begin
						jj_q <= jj_q + 2'd1;
					end
					if ((pass_q == PS_NORM_SQ) && (acc_q == '0)) begin
						deg_q <= 1'b1;
					end
				end else begin
					cyc_q <= cyc_q + 3'd1;
				end
			end

			case (state_q)
				ST_SQRT, ST_DIV: step_q <= step_q + STEP_W'(1);
				default:         step_q <= '0;
			endcase

			if (state_q == ST_DIV_END) begin
				dsel_q <= !dsel_q;
			end

			// The alignment rebuilds the ground pose from the unit forward axis.
			if (state_q == ST_ALIGN) begin
				gr_q    <= align_mat;
				gt_q[0] <= tt_q[0];
				gt_q[1] <= '0;
				gt_q[2] <= tt_q[2];
			end

			// The space pose is replaced once all products that read it are done.
			if (elem_end && pass_last && (pass_q == PS_OUT_POS) &&
				((op_q == OP_NEXT_SPACE) || (op_q == OP_LOAD_SPACE))) begin
				sr_q <= pmat;
				st_q <= ppos;
			end

			if (state_q == ST_DONE && (!result_valid_q || !result_stall)) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			pin_q <= pose;
			op_q  <= pose.operation;
		end

		if (state_q == ST_MAC) begin
			if (cyc_q < 3'd3) begin
				prod_s1 <= PROD_W'(a_op) * PROD_W'(b_op);
			end
			if (cyc_q == 3'd1) begin
				acc_q <= ACC_W'(prod_s1);
			end else if (cyc_q == 3'd2 || cyc_q == 3'd3) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end

		if (elem_end) begin
			case (pass_q)
				PS_REL_ROT:  ta_q[ii_q][jj_q] <= ent_sat;
				PS_REL_POS:  trel_q[ii_q] <= pos_sat;
				PS_GND_ROT:  tb_q[ii_q][jj_q] <= ent_sat;
				PS_GND_POS:  tt_q[ii_q] <= pos_sat;
				PS_LOAD_ROT: tb_q[ii_q][jj_q] <= ent_sat;
				PS_LOAD_POS: tt_q[ii_q] <= pos_sat;
				PS_NORM_SQ: begin
					sq_q   <= {acc_q[SQ_W-1:0], (2 * NORM_SHIFT)'(0)};
					root_q <= '0;
					rem_q  <= '0;
				end
				PS_OUT_ROT:  ta_q[ii_q][jj_q] <= ent_sat;
				PS_OUT_POS:  trel_q[ii_q] <= pos_sat;
				default: ;
			endcase
		end

		case (state_q)
			ST_SQRT: begin
				// One root bit per cycle, two radicand bits shifted in.
				sq_q <= sq_q << 2;
				if (sq_rem >= sq_trial) begin
					rem_q  <= sq_rem - sq_trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= sq_rem;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			ST_DIV_INIT: begin
				dneg_q <= dv[ENT_W-1];
				dsat_q <= CMP_W'(num) >= CMP_W'({root_q, QUO_W'(0)});
				rem_q  <= REM_W'(num >> QUO_W);
				sq_q[X_W-1 -: QUO_W] <= num[QUO_W-1:0];
				quo_q  <= '0;
			end
			ST_DIV: begin
				// Restoring division, one quotient bit per cycle.
				sq_q <= sq_q << 1;
				if (dv_rem >= {1'b0, root_q}) begin
					rem_q <= REM_W'(dv_rem - {1'b0, root_q});
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= REM_W'(dv_rem);
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			ST_DIV_END: begin
				if (dsel_q) begin
					uc_q <= unit;
				end else begin
					ua_q <= unit;
				end
			end
			default: ;
		endcase

		if (state_q == ST_DONE && (!result_valid_q || !result_stall)) begin
			result_q.out_rot_row0 <= {ta_q[0][0], ta_q[0][1], ta_q[0][2]};
			result_q.out_rot_row1 <= {ta_q[1][0], ta_q[1][1], ta_q[1][2]};
			result_q.out_rot_row2 <= {ta_q[2][0], ta_q[2][1], ta_q[2][2]};
			result_q.out_pos_x    <= trel_q[0];
			result_q.out_pos_y    <= trel_q[1];
			result_q.out_pos_z    <= trel_q[2];
			result_q.degenerate   <= deg_q;
		end
	end

	assign out_col0_zero = (result_q.out_rot_row0[ROW_W-1 -: ENT_W] == '0) &&
		(result_q.out_rot_row1[ROW_W-1 -: ENT_W] == '0) &&
		(result_q.out_rot_row2[ROW_W-1 -: ENT_W] == '0);

	// A result appears only when the sequencer finishes a request.
	`GPPI_ASSERT_IMPLY(a_result_from_done, clk, arst_n, $rose(result_valid_q), $past(state_q) == ST_DONE)

	// A degenerate axis leaves the first ground column zero, so its world image is zero.
	`GPPI_ASSERT_IMPLY(a_degenerate_col, clk, arst_n, result_valid_q && result_q.degenerate, out_col0_zero)

	// The divider remainder stays below the divisor unless the quotient saturates.
	`GPPI_ASSERT_IMPLY(a_div_rem_bound, clk, arst_n, (state_q == ST_DIV) && !dsat_q, rem_q < REM_W'(root_q))

	// After the alignment the ground up axis is the unit entry.
	`GPPI_ASSERT_NEXT(a_align_up_axis, clk, arst_n, state_q == ST_ALIGN, $signed(gr_q[1][1]) == ENT_ONE)

endmodule
